// File: hdl/idr_pkg.sv
// Shared types and constants for the ignition dwell retimer.
// Used by idr_measure and ignition_dwell_retimer; depends on nothing else.
`default_nettype none

package idr_pkg;

    // Width of tick counter, start and due times, and the shared delay
    localparam int TIMER_BITS = 16;

    // Configuration register field widths
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int WARMUP_BITS   = 8;

    typedef logic [TIMER_BITS-1:0]    t_timer;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;
    typedef logic [CFG_IDX_BITS-1:0]  t_cfg_idx;
    typedef logic [WARMUP_BITS-1:0]   t_warmup;

    // Register indexes
    localparam t_cfg_idx REG_NORMAL_OFFSET = 2'd0;
    localparam t_cfg_idx REG_WARMUP_OFFSET = 2'd1;
    localparam t_cfg_idx REG_WARMUP_LIMIT  = 2'd2;
    localparam t_cfg_idx REG_INITIAL_DELAY = 2'd3;

    // Register reset values
    localparam t_cfg_data RST_NORMAL_OFFSET = 16'd70;
    localparam t_cfg_data RST_WARMUP_OFFSET = 16'd109;
    localparam t_warmup   RST_WARMUP_LIMIT  = 8'd20;
    localparam t_cfg_data RST_INITIAL_DELAY = 16'd40;

    // Warm-up counter stops here
    localparam t_warmup WARMUP_MAX = {WARMUP_BITS{1'b1}};

    // Offsets used by the delay measurement
    typedef struct packed {
        t_cfg_data normal_offset;
        t_cfg_data warmup_offset;
        t_warmup   warmup_limit;
    } t_meas_cfg;

endpackage

`default_nettype wire

// File: hdl/ignition_dwell_retimer.sv
// Top level of the two-channel ignition pulse retimer.
// Depends on idr_pkg and instantiates idr_measure once per channel.
//
// Usage:
//   Input channel (i_valid/o_ready): one transfer per prescaled timer tick,
//   carrying the levels of both trigger inputs.
//   Output channel (o_valid/i_ready): one transfer per input tick, carrying
//   both coil drives (1 off, 0 firing) after that tick is processed.
//   Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
//   (0 normal offset, 1 warm-up offset, 2 warm-up limit, 3 initial delay)
//   at the clock edge; write only while no tick is in flight.
//   Latency: the result of a tick is presented the cycle after its transfer.
//   Throughput: one tick per cycle unless stalled; the edge, subtract and
//   compare logic for both channels sits between state and result registers.
//   Stall: while a result waits, a new tick is taken in the same cycle the
//   waiting result leaves; with i_ready low the result holds and o_ready
//   drops until it is taken.
//   Reset (i_rst_n low, synchronous): tick counter, edges, arms and warm-up
//   count clear, both coils go off, registers return to their defaults and
//   the delay falls back to the initial delay.
`default_nettype none

module ignition_dwell_retimer (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire                     i_trigger_14,
    input  wire                     i_trigger_23,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic                    o_coil_14,
    output logic                    o_coil_23,
    input  wire                     i_cfg_we,
    input  wire idr_pkg::t_cfg_idx  i_cfg_idx,
    input  wire idr_pkg::t_cfg_data i_cfg_wdata
);
    import idr_pkg::*;

    // Configuration registers
    t_meas_cfg r_cfg;
    t_cfg_data r_initial_delay;

    // Block state
    t_timer  r_tick, n_tick;
    logic    r_prev_14, n_prev_14, r_prev_23, n_prev_23;
    t_timer  r_start_14, n_start_14, r_start_23, n_start_23;
    t_timer  r_due_14, n_due_14, r_due_23, n_due_23;
    logic    r_armed_14, n_armed_14, r_armed_23, n_armed_23;
    t_timer  r_shared_delay, n_shared_delay;
    logic    r_measured, n_measured;
    t_warmup r_warmup, n_warmup;
    logic    r_drive_14, n_drive_14, r_drive_23, n_drive_23;
    logic    r_out_valid;

    logic    accept;
    logic    rise_14, fall_14, rise_23, fall_23;
    t_timer  delay_0, delay_1;
    t_timer  meas_14, meas_23;
    t_warmup warmup_14, warmup_23, warmup_mid;
    logic    arm_14, arm_23;

    assign o_ready   = !r_out_valid || i_ready;
    assign accept    = i_valid && o_ready;
    assign o_valid   = r_out_valid;
    assign o_coil_14 = r_drive_14;
    assign o_coil_23 = r_drive_23;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_offset <= RST_NORMAL_OFFSET;
            r_cfg.warmup_offset <= RST_WARMUP_OFFSET;
            r_cfg.warmup_limit  <= RST_WARMUP_LIMIT;
            r_initial_delay     <= RST_INITIAL_DELAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NORMAL_OFFSET: r_cfg.normal_offset <= i_cfg_wdata;
                REG_WARMUP_OFFSET: r_cfg.warmup_offset <= i_cfg_wdata;
                REG_WARMUP_LIMIT:  r_cfg.warmup_limit  <= i_cfg_wdata[WARMUP_BITS-1:0];
                REG_INITIAL_DELAY: r_initial_delay     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Detect trigger edges
    assign rise_14 =  i_trigger_14 && !r_prev_14;
    assign fall_14 = !i_trigger_14 &&  r_prev_14;
    assign rise_23 =  i_trigger_23 && !r_prev_23;
    assign fall_23 = !i_trigger_23 &&  r_prev_23;

    // Measure channel 14 first, then channel 23 on the updated warm-up count
    idr_measure u_meas_14 (
        .i_tick         (r_tick),
        .i_start        (r_start_14),
        .i_cfg          (r_cfg),
        .i_warmup_count (r_warmup),
        .o_delay        (meas_14),
        .o_warmup_count (warmup_14)
    );

    assign warmup_mid = fall_14 ? warmup_14 : r_warmup;

    idr_measure u_meas_23 (
        .i_tick         (r_tick),
        .i_start        (r_start_23),
        .i_cfg          (r_cfg),
        .i_warmup_count (warmup_mid),
        .o_delay        (meas_23),
        .o_warmup_count (warmup_23)
    );

    // Delay seen by channel 14, then by channel 23 after 14's measurement
    assign delay_0 = r_measured ? r_shared_delay : t_timer'(r_initial_delay);
    assign delay_1 = fall_14 ? meas_14 : delay_0;

    // Next state for one tick
    always_comb begin
        n_prev_14      = i_trigger_14;
        n_prev_23      = i_trigger_23;
        n_start_14     = rise_14 ? r_tick : r_start_14;
        n_start_23     = rise_23 ? r_tick : r_start_23;
        n_due_14       = rise_14 ? r_tick + delay_0 : r_due_14;
        n_due_23       = rise_23 ? r_tick + delay_1 : r_due_23;
        arm_14         = rise_14 || r_armed_14;
        arm_23         = rise_23 || r_armed_23;
        n_drive_14     = fall_14 ? 1'b1 : r_drive_14;
        n_drive_23     = fall_23 ? 1'b1 : r_drive_23;
        n_shared_delay = fall_23 ? meas_23 : (fall_14 ? meas_14 : r_shared_delay);
        n_measured     = r_measured || fall_14 || fall_23;
        n_warmup       = fall_23 ? warmup_23 : warmup_mid;
        n_armed_14     = arm_14;
        n_armed_23     = arm_23;

        // Fire due channels and disarm
        if (arm_23 && (n_due_23 <= r_tick)) begin
            n_drive_23 = 1'b0;
            n_armed_23 = 1'b0;
        end
        if (arm_14 && (n_due_14 <= r_tick)) begin
            n_drive_14 = 1'b0;
            n_armed_14 = 1'b0;
        end

        n_tick = r_tick + t_timer'(1);
    end

    // Update state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_prev_14  <= 1'b0;
            r_prev_23  <= 1'b0;
            r_start_14 <= '0;
            r_start_23 <= '0;
            r_due_14   <= '0;
            r_due_23   <= '0;
            r_armed_14 <= 1'b0;
            r_armed_23 <= 1'b0;
            r_measured <= 1'b0;
            r_warmup   <= '0;
            r_drive_14 <= 1'b1;
            r_drive_23 <= 1'b1;
        end else if (accept) begin
            r_tick     <= n_tick;
            r_prev_14  <= n_prev_14;
            r_prev_23  <= n_prev_23;
            r_start_14 <= n_start_14;
            r_start_23 <= n_start_23;
            r_due_14   <= n_due_14;
            r_due_23   <= n_due_23;
            r_armed_14 <= n_armed_14;
            r_armed_23 <= n_armed_23;
            r_measured <= n_measured;
            r_warmup   <= n_warmup;
            r_drive_14 <= n_drive_14;
            r_drive_23 <= n_drive_23;
        end
    end

    // Hold the measured delay; only meaningful once a pulse has been measured
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_shared_delay <= n_shared_delay;
        end
    end

    // Present one result per transfer; hold it until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: hdl/idr_measure.sv
// Pulse width measurement: width minus offset, clamped at zero, with warm-up.
// Depends on idr_pkg for the timer type and the offset bundle.
`default_nettype none

module idr_measure (
    input  wire idr_pkg::t_timer    i_tick,
    input  wire idr_pkg::t_timer    i_start,
    input  wire idr_pkg::t_meas_cfg i_cfg,
    input  wire idr_pkg::t_warmup   i_warmup_count,
    output idr_pkg::t_timer         o_delay,
    output idr_pkg::t_warmup        o_warmup_count
);
    import idr_pkg::*;

    logic   use_warmup;
    t_timer offset;
    t_timer diff;

    // Pick the offset; warm-up applies while the counter is at most the limit
    assign use_warmup = (i_warmup_count <= i_cfg.warmup_limit);
    assign offset     = use_warmup ? t_timer'(i_cfg.warmup_offset)
                                   : t_timer'(i_cfg.normal_offset);

    // Advance the shared warm-up counter during warm-up, saturating
    assign o_warmup_count = (use_warmup && (i_warmup_count != WARMUP_MAX))
                          ? i_warmup_count + t_warmup'(1) : i_warmup_count;

    // Width minus offset as two's complement; clamp negative to zero
    assign diff    = i_tick - i_start - offset;
    assign o_delay = diff[TIMER_BITS-1] ? '0 : diff;

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for ignition_dwell_retimer: trigger ticks go in over valid/ready,
// a local model of both channels predicts the coil levels and every result is checked in order.
// Depends on idr_pkg and the ignition_dwell_retimer RTL.

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import idr_pkg::*;

    localparam int CH14         = 0;
    localparam int CH23         = 1;
    localparam int IDLE_PCT     = 30;
    localparam int NOISE_PCT    = 4;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_SPACING = 5000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RUN_LIMIT_NS = 10_000_000;

    // Directed tick pairs {trig_14, trig_23}, first pair in the top bits
    localparam logic [39:0] DIRECTED_TICKS =
        40'b11_11_11_10_00_11_00_10_01_11_00_11_10_01_00_01_11_01_10_00;

    typedef struct packed {
        logic trig_14;
        logic trig_23;
    } t_tick;

    typedef struct packed {
        logic coil_14;
        logic coil_23;
    } t_coils;

    // DUT ports
    logic      i_clk        = 1'b0;
    logic      i_rst_n      = 1'b0;
    logic      i_valid      = 1'b0;
    logic      i_trigger_14 = 1'b0;
    logic      i_trigger_23 = 1'b0;
    logic      i_ready      = 1'b0;
    logic      i_cfg_we     = 1'b0;
    t_cfg_idx  i_cfg_idx    = REG_NORMAL_OFFSET;
    t_cfg_data i_cfg_wdata  = '0;
    logic      o_ready;
    logic      o_valid;
    logic      o_coil_14;
    logic      o_coil_23;

    // Pending ticks and expected coil levels
    t_tick  tick_q[$];
    t_coils coil_q[$];

    // Mirror of the retimer registers and state
    t_cfg_data m_normal_ofs;
    t_cfg_data m_warmup_ofs;
    t_cfg_data m_init_delay;
    t_warmup   m_warmup_lim;
    t_timer    m_tick;
    t_timer    m_delay;
    t_timer    m_start[2];
    t_timer    m_due[2];
    logic      m_prev[2];
    logic      m_armed[2];
    logic      m_coil[2];
    logic      m_measured;
    t_warmup   m_warmup_cnt;

    // Pulse generator state
    logic gen_lvl[2]   = '{1'b0, 1'b0};
    int   gen_left[2]  = '{0, 0};
    int   noise_left   = 0;
    int   queued_ticks = 0;

    int     n_errors     = 0;
    int     n_results    = 0;
    int     n_cfg_writes = 0;
    int     n_settings   = 0;
    int     n_taken      = 0;
    int     hold_left    = 0;
    int     next_hold    = 300;
    longint cyc          = 0;
    logic   no_idle;

    ignition_dwell_retimer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_trigger_14 (i_trigger_14),
        .i_trigger_23 (i_trigger_23),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_coil_14    (o_coil_14),
        .o_coil_23    (o_coil_23),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Count cycles; keep one window free of random idling
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    assign no_idle = (cyc >= 2000 && cyc < 2800);

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        n_errors++;
    endtask

    task automatic reset_model();
        m_normal_ofs = RST_NORMAL_OFFSET;
        m_warmup_ofs = RST_WARMUP_OFFSET;
        m_warmup_lim = RST_WARMUP_LIMIT;
        m_init_delay = RST_INITIAL_DELAY;
        m_tick       = '0;
        m_delay      = t_timer'(RST_INITIAL_DELAY);
        m_measured   = 1'b0;
        m_warmup_cnt = '0;
        for (int ch = 0; ch < 2; ch++) begin
            m_start[ch] = '0;
            m_due[ch]   = '0;
            m_prev[ch]  = 1'b0;
            m_armed[ch] = 1'b0;
            m_coil[ch]  = 1'b1;
        end
    endtask

    // Derive the shared delay from the pulse that just ended on this channel
    task automatic measure_width(input int ch);
        t_cfg_data ofs;
        t_timer    d;
        ofs = m_normal_ofs;
        if (m_warmup_cnt <= m_warmup_lim) begin
            ofs = m_warmup_ofs;
            if (m_warmup_cnt != WARMUP_MAX)
                m_warmup_cnt++;
        end
        d = m_tick - m_start[ch] - t_timer'(ofs);
        if (d[TIMER_BITS-1])
            d = '0;
        m_delay    = d;
        m_measured = 1'b1;
    endtask

    task automatic step_channel(input int ch, input logic lvl);
        t_timer dly;
        if (!lvl && m_prev[ch]) begin
            m_coil[ch] = 1'b1;
            measure_width(ch);
            m_prev[ch] = 1'b0;
        end else if (lvl && !m_prev[ch]) begin
            dly = m_measured ? m_delay : t_timer'(m_init_delay);
            m_start[ch] = m_tick;
            m_due[ch]   = m_tick + dly;
            m_armed[ch] = 1'b1;
            m_prev[ch]  = 1'b1;
        end
    endtask

    // Advance the model by one tick and return the coil levels it leaves
    task automatic predict_coils(input t_tick t, output t_coils c);
        step_channel(CH14, t.trig_14);
        step_channel(CH23, t.trig_23);
        for (int ch = 0; ch < 2; ch++) begin
            if (m_armed[ch] && m_due[ch] <= m_tick) begin
                m_coil[ch]  = 1'b0;
                m_armed[ch] = 1'b0;
            end
        end
        m_tick++;
        c.coil_14 = m_coil[CH14];
        c.coil_23 = m_coil[CH23];
    endtask

    // Driver: offer the next pending tick, idling at random
    always @(posedge i_clk) begin : driver
        t_tick t;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (tick_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                t = tick_q.pop_front();
                i_valid      <= 1'b1;
                i_trigger_14 <= t.trig_14;
                i_trigger_23 <= t.trig_23;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                n_taken++;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (n_taken >= next_hold) begin
                hold_left = HOLD_CYCLES;
                next_hold += HOLD_SPACING;
                i_ready <= 1'b0;
            end else begin
                i_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Monitor: check each result transfer, track register writes, predict each tick transfer
    always @(posedge i_clk) begin : monitor
        t_coils want;
        t_tick  t;
        if (!i_rst_n) begin
            reset_model();
            coil_q.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (coil_q.size() == 0) begin
                    report_mismatch($sformatf("coil result %b%b with no tick pending",
                                              o_coil_14, o_coil_23));
                end else begin
                    want = coil_q.pop_front();
                    if (o_coil_14 !== want.coil_14)
                        report_mismatch($sformatf("result %0d coil_14 got %b want %b",
                                                  n_results, o_coil_14, want.coil_14));
                    if (o_coil_23 !== want.coil_23)
                        report_mismatch($sformatf("result %0d coil_23 got %b want %b",
                                                  n_results, o_coil_23, want.coil_23));
                end
                n_results++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NORMAL_OFFSET: m_normal_ofs = i_cfg_wdata;
                    REG_WARMUP_OFFSET: m_warmup_ofs = i_cfg_wdata;
                    REG_WARMUP_LIMIT:  m_warmup_lim = t_warmup'(i_cfg_wdata);
                    REG_INITIAL_DELAY: m_init_delay = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                t.trig_14 = i_trigger_14;
                t.trig_23 = i_trigger_23;
                predict_coils(t, want);
                coil_q.push_back(want);
            end
        end
    end

    task automatic queue_tick(input logic t14, input logic t23);
        t_tick t;
        t.trig_14 = t14;
        t.trig_23 = t23;
        tick_q.push_back(t);
        queued_ticks++;
    endtask

    // Queue independent pulse trains on both channels, with short bursts of noise
    task automatic gen_pulses(input int n, input int wmin, input int wmax,
                              input int gmin, input int gmax);
        logic lvl[2];
        for (int i = 0; i < n; i++) begin
            for (int ch = 0; ch < 2; ch++) begin
                if (gen_left[ch] <= 0) begin
                    gen_lvl[ch]  = !gen_lvl[ch];
                    gen_left[ch] = gen_lvl[ch] ? $urandom_range(wmax, wmin)
                                               : $urandom_range(gmax, gmin);
                end
                gen_left[ch]--;
                lvl[ch] = gen_lvl[ch];
            end
            if (noise_left == 0 && $urandom_range(99) < NOISE_PCT)
                noise_left = $urandom_range(6, 1);
            if (noise_left > 0) begin
                lvl[CH14] = 1'($urandom_range(1));
                lvl[CH23] = 1'($urandom_range(1));
                noise_left--;
            end
            queue_tick(lvl[CH14], lvl[CH23]);
        end
    endtask

    // Hold until every tick is sent and every result is back, then let the pipe settle
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (tick_q.size() != 0 || i_valid || coil_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input t_cfg_data val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_cfg_writes++;
    endtask

    task automatic set_regs(input t_cfg_data nrm, input t_cfg_data wrm,
                            input t_cfg_data lim, input t_cfg_data init);
        cfg_write(REG_NORMAL_OFFSET, nrm);
        cfg_write(REG_WARMUP_OFFSET, wrm);
        cfg_write(REG_WARMUP_LIMIT, lim);
        cfg_write(REG_INITIAL_DELAY, init);
        n_settings++;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Arm channel 14 with the reset delay, then shorten the initial delay
        @(negedge i_clk);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b1, 1'b0);
        wait_drained();
        cfg_write(REG_INITIAL_DELAY, t_cfg_data'(2));
        n_settings++;

        // Directed edges: joint rise, early fall, zero delay, re-arm while armed
        @(negedge i_clk);
        for (int i = 19; i >= 0; i--)
            queue_tick(DIRECTED_TICKS[2*i+1], DIRECTED_TICKS[2*i]);

        // Reset offsets with long pulses
        gen_pulses(300, 60, 220, 10, 120);
        wait_drained();

        // Zero offsets: delay equals the measured width
        set_regs('0, '0, '0, 16'hFFFF);
        gen_pulses(250, 1, 40, 1, 40);
        wait_drained();

        // Largest offsets, warm-up always on
        set_regs(16'hFFFF, 16'hFFFF, t_cfg_data'(8'hFF), '0);
        gen_pulses(250, 1, 40, 1, 40);
        wait_drained();

        // Small random offsets and limit, random initial delay
        set_regs(t_cfg_data'($urandom_range(60)), t_cfg_data'($urandom_range(60)),
                 t_cfg_data'($urandom_range(40)), t_cfg_data'($urandom));
        gen_pulses(250, 1, 80, 1, 60);
        wait_drained();

        // Full-range random settings
        set_regs(t_cfg_data'($urandom), t_cfg_data'($urandom),
                 t_cfg_data'($urandom_range(255)), t_cfg_data'($urandom));
        gen_pulses(250, 1, 300, 1, 100);
        wait_drained();

        // Restart both pulse trains and pulse densely under small offsets
        set_regs(t_cfg_data'($urandom_range(30)), t_cfg_data'($urandom_range(30)), '0,
                 t_cfg_data'($urandom_range(100)));
        gen_left[CH14] = 0;
        gen_left[CH23] = 0;
        gen_pulses(300, 1, 50, 1, 40);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d ticks under %0d register settings (%0d writes), checked %0d results.",
                 queued_ticks, n_settings, n_cfg_writes, n_results);
        $display("Covered directed edges, offset and warm-up extremes, noise and long stalls.");
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Guard against a hung handshake
    initial begin : watchdog
        #RUN_LIMIT_NS;
        $display("Timeout with %0d ticks pending and %0d results outstanding.",
                 tick_q.size(), coil_q.size());
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
hdl/idr_pkg.sv
hdl/idr_measure.sv
hdl/ignition_dwell_retimer.sv
dv/tb.sv
